// File: design/sppt_pkg.sv
package sppt_pkg;

    // Port write kinds
    typedef enum logic {
        OP_DATA = 1'b0,     // data bus: coil phases, X low nibble, Y high nibble
        OP_CTRL = 1'b1      // control port: pen line
    } t_op;

    // Full-step coil sequence, in ring order
    localparam logic [3:0] PH_0 = 4'hA;
    localparam logic [3:0] PH_1 = 4'h6;
    localparam logic [3:0] PH_2 = 4'h5;
    localparam logic [3:0] PH_3 = 4'h9;

    // Ring distance codes
    localparam logic [1:0] STEP_FWD  = 2'd1;
    localparam logic [1:0] STEP_BACK = 2'd3;

    // Pen line bit on a control write, 0 = down
    localparam int PEN_BIT = 1;

    // Reset value of the last-dot position (counts as already emitted)
    localparam logic [31:0] EMIT_RESET = 32'd999999;

    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
    } t_ring;

    function automatic t_ring ring_pos(input logic [3:0] p);
        t_ring r;
        r.hit = 1'b1;
        r.idx = 2'd0;
        case (p)
            PH_0:    r.idx = 2'd0;
            PH_1:    r.idx = 2'd1;
            PH_2:    r.idx = 2'd2;
            PH_3:    r.idx = 2'd3;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: design/sppt_axis_step.sv
module sppt_axis_step import sppt_pkg::*; #(
    parameter int POS_WIDTH = 32
) (
    input  logic                 i_seen,
    input  logic [3:0]           i_prev,
    input  logic [3:0]           i_new,
    input  logic [POS_WIDTH-1:0] i_pos,
    output logic [POS_WIDTH-1:0] o_pos
);

    t_ring      w_old;
    t_ring      w_new;
    logic [1:0] w_dist;

    assign w_old  = ring_pos(i_prev);
    assign w_new  = ring_pos(i_new);
    assign w_dist = w_new.idx - w_old.idx;

    // one place forward or back moves; half-ring jump or unknown pattern holds
    always_comb begin
        o_pos = i_pos;
        if (i_seen && (i_new != i_prev) && w_old.hit && w_new.hit) begin
            if (w_dist == STEP_FWD) begin
                o_pos = i_pos + POS_WIDTH'(1);
            end else if (w_dist == STEP_BACK) begin
                o_pos = i_pos - POS_WIDTH'(1);
            end
        end
    end

endmodule

// File: design/stepper_phase_position_tracker.sv
// An accepted beat waits in the input register until the dot register is free; its dot then shows on o_valid.
// Throughput: one input beat per cycle, sustained while the dot side does not stall.
// Input register, then a single decode/update pass into the dot register.
// Reset: synchronous, active low; positions clear, pen up, last-dot pair set to 999999,
// first data write after reset only records the coil phases.
module stepper_phase_position_tracker import sppt_pkg::*; #(
    parameter int POS_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // port write beats
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [0:0]         i_opcode,
    input  logic [7:0]         i_port_value,
    input  logic [31:0]        i_time_stamp,
    // dot beats
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_dot_x,
    output logic signed [31:0] o_dot_y,
    output logic [31:0]        o_dot_time
);

    // ------------------------------------------------------------------
    // Handshake: input register (s1) feeds the dot register (s2).
    // s2 can load whenever it is empty or its dot leaves this cycle, so
    // the input side only stalls when s1 holds a beat and s2 is blocked.
    // ------------------------------------------------------------------
    logic w_s2_free;
    logic w_s1_adv;
    logic w_s1_load;

    logic        r_s1_valid;
    t_op         r_s1_op;
    logic [7:0]  r_s1_val;
    logic [31:0] r_s1_time;

    logic        r_out_valid;

    assign w_s2_free = !r_out_valid || !i_stall;
    assign w_s1_adv  = r_s1_valid && w_s2_free;
    assign o_stall   = r_s1_valid && !w_s2_free;
    assign w_s1_load = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Tracker state
    // ------------------------------------------------------------------
    logic [3:0]           r_prev_x;
    logic [3:0]           r_prev_y;
    logic                 r_seen;      // both axes are always seen together
    logic [POS_WIDTH-1:0] r_pos_x;
    logic [POS_WIDTH-1:0] r_pos_y;
    logic                 r_pen_up;
    logic [POS_WIDTH-1:0] r_emit_x;
    logic [POS_WIDTH-1:0] r_emit_y;

    logic signed [31:0]   r_dot_x;
    logic signed [31:0]   r_dot_y;
    logic [31:0]          r_dot_time;

    // ------------------------------------------------------------------
    // Single pass decode of the held beat
    // ------------------------------------------------------------------
    logic                 w_is_data;
    logic [POS_WIDTH-1:0] w_step_x;
    logic [POS_WIDTH-1:0] w_step_y;
    logic [POS_WIDTH-1:0] n_pos_x;
    logic [POS_WIDTH-1:0] n_pos_y;
    logic                 w_pen_down;
    logic                 w_dot;
    logic signed [63:0]   w_ext_x;
    logic signed [63:0]   w_ext_y;
    logic signed [63:0]   w_emit_ext_x;
    logic signed [63:0]   w_emit_ext_y;

    assign w_is_data = (r_s1_op == OP_DATA);

    sppt_axis_step #(.POS_WIDTH(POS_WIDTH)) u_axis_x (
        .i_seen (r_seen),
        .i_prev (r_prev_x),
        .i_new  (r_s1_val[3:0]),
        .i_pos  (r_pos_x),
        .o_pos  (w_step_x)
    );

    sppt_axis_step #(.POS_WIDTH(POS_WIDTH)) u_axis_y (
        .i_seen (r_seen),
        .i_prev (r_prev_y),
        .i_new  (r_s1_val[7:4]),
        .i_pos  (r_pos_y),
        .o_pos  (w_step_y)
    );

    assign n_pos_x = w_is_data ? w_step_x : r_pos_x;
    assign n_pos_y = w_is_data ? w_step_y : r_pos_y;

    // data write uses the stored pen; control write uses the new pen bit
    assign w_pen_down = w_is_data ? !r_pen_up : !r_s1_val[PEN_BIT];
    assign w_dot      = w_pen_down && ((n_pos_x != r_emit_x) || (n_pos_y != r_emit_y));

    // sign-extend from POS_WIDTH, then cut to the 32-bit dot fields
    assign w_ext_x      = 64'(signed'(n_pos_x));
    assign w_ext_y      = 64'(signed'(n_pos_y));
    assign w_emit_ext_x = 64'(signed'(r_emit_x));
    assign w_emit_ext_y = 64'(signed'(r_emit_y));

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_x    <= 4'd0;
            r_prev_y    <= 4'd0;
            r_seen      <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pen_up    <= 1'b1;
            r_emit_x    <= POS_WIDTH'(EMIT_RESET);
            r_emit_y    <= POS_WIDTH'(EMIT_RESET);
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s2_free) begin
                r_out_valid <= w_s1_adv && w_dot;
            end

            if (w_s1_adv) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                if (w_is_data) begin
                    r_prev_x <= r_s1_val[3:0];
                    r_prev_y <= r_s1_val[7:4];
                    r_seen   <= 1'b1;
                end else begin
                    r_pen_up <= r_s1_val[PEN_BIT];
                end
                if (w_dot) begin
                    r_emit_x <= n_pos_x;
                    r_emit_y <= n_pos_y;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_op   <= t_op'(i_opcode);
            r_s1_val  <= i_port_value;
            r_s1_time <= i_time_stamp;
        end
        if (w_s1_adv && w_dot) begin
            r_dot_x    <= w_ext_x[31:0];
            r_dot_y    <= w_ext_y[31:0];
            r_dot_time <= r_s1_time;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_dot_x    = r_dot_x;
    assign o_dot_y    = r_dot_y;
    assign o_dot_time = r_dot_time;

`ifndef NO_ASSERTIONS
    // a fresh dot leaves the last-dot pair equal to the tracked position
    a_new_dot_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_emit_x == r_pos_x) && (r_emit_y == r_pos_y))
        else $error("dot loaded without updating last-dot pair");

    // a pending dot always shows the last-dot pair
    a_dot_is_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_dot_x == w_emit_ext_x[31:0]) && (r_dot_y == w_emit_ext_y[31:0]))
        else $error("dot fields disagree with last-dot pair");

    // no beat is processed while a dot is held back
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_pos_x) && $stable(r_pos_y)
                                     && $stable(r_pen_up))
        else $error("tracker state moved while dot was stalled");
`endif

endmodule

// File: tb/stepper_phase_position_tracker_tb.sv
module stepper_phase_position_tracker_tb import sppt_pkg::*; ();

    localparam int POS_W          = 32;
    localparam int DRAIN_CYCLES   = 8;     // extra wait after the last expected dot is out
    localparam int LONG_HOLD      = 300;   // receiver hold-off used to back the block up
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
    localparam int MAX_REPORTS    = 10;

    // one port write as offered to the block
    typedef struct {
        t_op         op;
        logic [7:0]  val;
        logic [31:0] ts;
    } t_write;

    // one dot as it leaves the block
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        ts;
    } t_dot;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [0:0]         i_opcode = '0;
    logic [7:0]         i_port_value = '0;
    logic [31:0]        i_time_stamp = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_dot_x;
    logic signed [31:0] o_dot_y;
    logic [31:0]        o_dot_time;

    stepper_phase_position_tracker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_port_value (i_port_value),
        .i_time_stamp (i_time_stamp),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_dot_x      (o_dot_x),
        .o_dot_y      (o_dot_y),
        .o_dot_time   (o_dot_time)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Tracker state mirrored on the bench side. Index 0 is X, 1 is Y.
    // ------------------------------------------------------------------
    logic [3:0]       last_coil [2];
    bit               coil_known [2];
    logic [POS_W-1:0] axis_pos [2];
    logic [POS_W-1:0] last_dot_pos [2];
    bit               pen_raised;

    t_write port_writes [$];   // writes waiting for the driver
    t_dot   dots_expected [$]; // predicted dots, oldest first

    // Knobs the stimulus sequence turns between phases
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    bit hold_ack  = 1'b0;
    int hold_left = 0;

    // Stimulus generator state: where each axis sits on the ring, and its heading
    logic [1:0]  gen_slot [2];
    bit          gen_fwd [2];
    logic [31:0] stamp_now;

    bit     beat_taken = 1'b0;   // input beat accepted at the last rising edge
    int     quiet_cycles = 0;
    int     mismatches = 0;
    int     n_writes = 0;
    int     n_ctrl = 0;
    int     n_dots = 0;
    t_write next_write;
    t_dot   want;

    // Ring slot of a coil pattern: {on_ring, slot}
    function automatic logic [2:0] coil_slot(input logic [3:0] p);
        case (p)
            PH_0:    return 3'b100;
            PH_1:    return 3'b101;
            PH_2:    return 3'b110;
            PH_3:    return 3'b111;
            default: return 3'b000;
        endcase
    endfunction

    function automatic logic [3:0] ring_coil(input logic [1:0] slot);
        case (slot)
            2'd0:    return PH_0;
            2'd1:    return PH_1;
            2'd2:    return PH_2;
            default: return PH_3;
        endcase
    endfunction

    // New axis position after the coils go from was to now
    function automatic logic [POS_W-1:0] step_axis(input logic [POS_W-1:0] p,
                                                  input logic [3:0] was,
                                                  input logic [3:0] now);
        logic [2:0] was_slot;
        logic [2:0] now_slot;
        logic [1:0] ring_dist;
        was_slot = coil_slot(was);
        now_slot = coil_slot(now);
        if (!was_slot[2] || !now_slot[2]) return p;
        ring_dist = now_slot[1:0] - was_slot[1:0];
        if (ring_dist == STEP_FWD) return p + 1'b1;
        if (ring_dist == STEP_BACK) return p - 1'b1;
        return p;   // same slot or half-ring jump
    endfunction

    // Apply one accepted write to the mirrored state, queue the dot it makes
    task automatic track_write(input t_write w);
        logic [3:0] nib [2];
        bit         pen_down_now;
        t_dot       d;
        nib[0] = w.val[3:0];
        nib[1] = w.val[7:4];
        if (w.op == OP_DATA) begin
            for (int a = 0; a < 2; a++) begin
                if (coil_known[a] && nib[a] != last_coil[a])
                    axis_pos[a] = step_axis(axis_pos[a], last_coil[a], nib[a]);
                last_coil[a]  = nib[a];
                coil_known[a] = 1'b1;
            end
            pen_down_now = !pen_raised;
        end else begin
            pen_down_now = !w.val[PEN_BIT];
        end
        if (pen_down_now &&
            (axis_pos[0] != last_dot_pos[0] || axis_pos[1] != last_dot_pos[1])) begin
            d.x  = 32'($signed(axis_pos[0]));
            d.y  = 32'($signed(axis_pos[1]));
            d.ts = w.ts;
            dots_expected.push_back(d);
            last_dot_pos = axis_pos;
        end
        // pen line is latched after the dot decision
        if (w.op == OP_CTRL) pen_raised = w.val[PEN_BIT];
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    function automatic logic [31:0] next_stamp();
        if ($urandom_range(99) < 80) begin
            stamp_now = stamp_now + $urandom_range(40, 1);
            return stamp_now;
        end
        return $urandom;
    endfunction

    task automatic queue_write(input t_op op, input logic [7:0] val, input logic [31:0] ts);
        t_write w;
        w.op  = op;
        w.val = val;
        w.ts  = ts;
        port_writes.push_back(w);
    endtask

    // Coil pattern for one axis: mostly clean steps along a heading that
    // flips now and then, with holds, half-ring jumps and stray patterns.
    function automatic logic [3:0] coil_for(input int a);
        int r;
        r = $urandom_range(99);
        if ($urandom_range(99) < 5) gen_fwd[a] = !gen_fwd[a];
        if (r < 70) begin
            gen_slot[a] = gen_fwd[a] ? gen_slot[a] + 2'd1 : gen_slot[a] - 2'd1;
        end else if (r < 80) begin
            // hold the current pattern
        end else if (r < 88) begin
            gen_slot[a] = gen_slot[a] + 2'd2;
        end else begin
            return 4'($urandom);
        end
        return ring_coil(gen_slot[a]);
    endfunction

    task automatic queue_random_writes(input int n);
        int         r;
        logic [7:0] v;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                // pen line, other bits random, mostly down
                v = 8'($urandom);
                v[PEN_BIT] = ($urandom_range(99) < 25);
                queue_write(OP_CTRL, v, next_stamp());
            end else if (r < 13) begin
                queue_write(t_op'($urandom_range(1)), 8'($urandom), next_stamp());
            end else begin
                queue_write(OP_DATA, {coil_for(1), coil_for(0)}, next_stamp());
            end
        end
    endtask

    // Wait until the driver has handed every queued write to the block
    task automatic wait_sent();
        while (port_writes.size() != 0 || i_valid) @(posedge i_clk);
    endtask

    // Sender stays quiet until every predicted dot has come out
    task automatic drain();
        wait_sent();
        while (dots_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next write at the falling edge once the current
    // beat has been taken; holds the payload steady while stalled.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || beat_taken)) begin
            if (port_writes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_write = port_writes.pop_front();
                i_valid      <= 1'b1;
                i_opcode     <= next_write.op;
                i_port_value <= next_write.val;
                i_time_stamp <= next_write.ts;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, check dot beats against the oldest
    // prediction, then fold accepted writes into the tracker.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_taken   <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            beat_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                n_dots++;
                if (dots_expected.size() == 0) begin
                    note_mismatch($sformatf("dot (%0d,%0d) t=%h with none expected",
                                            o_dot_x, o_dot_y, o_dot_time));
                end else begin
                    want = dots_expected.pop_front();
                    if (o_dot_x !== want.x)
                        note_mismatch($sformatf("dot x: expected %0d, got %0d",
                                                want.x, o_dot_x));
                    if (o_dot_y !== want.y)
                        note_mismatch($sformatf("dot y: expected %0d, got %0d",
                                                want.y, o_dot_y));
                    if (o_dot_time !== want.ts)
                        note_mismatch($sformatf("dot time: expected %h, got %h",
                                                want.ts, o_dot_time));
                end
            end
            if (i_valid && !o_stall) begin
                n_writes++;
                if (i_opcode == OP_CTRL) n_ctrl++;
                next_write.op  = t_op'(i_opcode);
                next_write.val = i_port_value;
                next_write.ts  = i_time_stamp;
                track_write(next_write);
            end
            // watchdog: nothing moving on either side for too long
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat for %0d cycles", quiet_cycles);
                $display("stepper_phase_position_tracker_tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        // tracker state after reset: pen up, last dot parked at 999999
        for (int a = 0; a < 2; a++) begin
            last_coil[a]    = 4'h0;
            coil_known[a]   = 1'b0;
            axis_pos[a]     = '0;
            last_dot_pos[a] = POS_W'(EMIT_RESET);
            gen_slot[a]     = 2'($urandom_range(3));
            gen_fwd[a]      = 1'($urandom_range(1));
        end
        pen_raised = 1'b1;
        stamp_now  = $urandom;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pen down at origin (differs from the parked 999999),
        // first data write only records phases, full ring forward, steps back,
        // half-ring jump, off-ring patterns, pen bit among other bits set.
        queue_write(OP_CTRL, 8'h00, 32'h0000_0000);
        queue_write(OP_CTRL, 8'hFD, 32'hFFFF_FFFF);
        queue_write(OP_DATA, {PH_0, PH_0}, next_stamp());
        queue_write(OP_DATA, {PH_1, PH_1}, next_stamp());
        queue_write(OP_DATA, {PH_2, PH_2}, next_stamp());
        queue_write(OP_DATA, {PH_3, PH_3}, next_stamp());
        queue_write(OP_DATA, {PH_0, PH_0}, next_stamp());   // ring wraps forward
        queue_write(OP_DATA, {PH_3, PH_0}, next_stamp());   // Y back across the wrap
        queue_write(OP_DATA, {PH_2, PH_0}, next_stamp());
        queue_write(OP_DATA, {PH_2, PH_2}, next_stamp());   // X half-ring jump
        queue_write(OP_DATA, 8'h0F, next_stamp());          // both off the ring
        queue_write(OP_DATA, {PH_1, PH_0}, next_stamp());   // leaving off-ring patterns
        queue_write(OP_DATA, {PH_1, PH_0}, next_stamp());   // no change
        queue_write(OP_CTRL, 8'h02, next_stamp());          // pen up
        queue_write(OP_DATA, {PH_2, PH_1}, next_stamp());   // moves, no dot while up
        queue_write(OP_CTRL, 8'h00, next_stamp());          // pen down: dot at new spot
        queue_write(OP_DATA, {PH_2, PH_0}, next_stamp());   // X back
        queue_write(OP_DATA, {PH_2, PH_3}, next_stamp());   // X back across the wrap
        queue_write(OP_DATA, {4'hF, PH_2}, next_stamp());
        queue_write(OP_CTRL, 8'hFF, 32'hFFFF_FFFF);         // pen up, all bits set
        queue_write(OP_CTRL, 8'h00, 32'h0000_0000);         // down, same spot: no dot
        queue_write(OP_DATA, 8'h00, next_stamp());
        queue_write(OP_DATA, 8'hFF, next_stamp());
        wait_sent();

        // no idling on either side
        queue_random_writes(450);
        wait_sent();

        // sender pauses until every dot is out
        drain();

        // receiver holds off while the sender keeps offering dot-making writes
        queue_write(OP_CTRL, 8'h00, next_stamp());
        for (int k = 0; k < 80; k++) begin
            gen_slot[0] = gen_slot[0] + 2'd1;
            gen_slot[1] = gen_slot[1] - 2'd1;
            queue_write(OP_DATA, {ring_coil(gen_slot[1]), ring_coil(gen_slot[0])},
                        next_stamp());
        end
        hold_req = !hold_req;
        wait_sent();

        idle_pct  = 45;
        stall_pct = 0;
        queue_random_writes(450);
        wait_sent();

        idle_pct  = 0;
        stall_pct = 45;
        queue_random_writes(450);
        wait_sent();

        idle_pct  = 29;
        stall_pct = 29;
        queue_random_writes(450);
        drain();

        $display("run: %0d port writes (%0d control) over four idle/stall mixes, %0d dots",
                 n_writes, n_ctrl, n_dots);
        $display("     plus a %0d-cycle receiver hold-off and a full drain mid-run; %0d %s",
                 LONG_HOLD, mismatches, "mismatches");
        if (mismatches == 0 && dots_expected.size() == 0) begin
            $display("stepper_phase_position_tracker_tb: PASS");
        end else begin
            $display("%0d dots missing", dots_expected.size());
            $display("stepper_phase_position_tracker_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: stepper_phase_position_tracker.f
design/sppt_pkg.sv
design/sppt_axis_step.sv
design/stepper_phase_position_tracker.sv
tb/stepper_phase_position_tracker_tb.sv
